// ----- rtl/core/pmft_pkg.sv -----
// Shared types and constants for the page-mapped flash translation block.
package pmft_pkg;

	localparam int BLOCKS          = 64;
	localparam int PAGES_PER_BLOCK = 32;
	localparam int LOGICAL_SECTORS = 1536;

	localparam int BLK_W  = $clog2(BLOCKS);
	localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
	localparam int PHYS_W = BLK_W + PG_W;
	localparam int SEC_W  = 11;
	localparam int MAP_W  = PHYS_W + 1;
	localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 2);
	localparam int CLR_W  = $clog2(LOGICAL_SECTORS + 1);

	// command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_OPEN  = 2'd2;

	// flash operation codes
	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_PROG  = 3'd1;
	localparam logic [2:0] OP_ERASE = 3'd2;
	localparam logic [2:0] OP_COPY  = 3'd3;
	localparam logic [2:0] OP_NONE  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [MAP_W-1:0] NO_MAP = {MAP_W{1'b1}};

	typedef struct packed {
		logic [1:0]       command;
		logic [SEC_W-1:0] sector;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       flash_op;
		logic [5:0]       target_block;
		logic [4:0]       target_page;
		logic [5:0]       source_block;
		logic [4:0]       source_page;
		logic [SEC_W-1:0] sector_tag;
		logic [1:0]       status;
		logic             last;
	} op_t;

endpackage

// ----- rtl/core/pmft_chan_if.sv -----
// Valid/ready channel carrying one payload of type T.
interface pmft_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pmft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pmft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/page_mapped_flash_translation.sv -----
// Page-mapped flash translation controller with greedy garbage collection.
//
// Requests arrive on cmd (command, sector) and the block answers on op with
// one or more flash operations per request; the final one carries last.
// cmd.ready is high only while the sequencer is idle: one request is worked
// on at a time. A read looks up the map and then answers. A plain write
// reads the map entry, decrements the old block's valid count when it
// replaces a mapped sector, reads the active block's count and programs.
// A write that finds the write block full first runs collection: it scans
// the per-block valid counts one RAM read a cycle, then works through each
// page of the victim block (owner read, map read, copy); the pace is
// set by the single read port of each table RAM.
// Results go through one output register; while the receiver stalls the
// sequencer holds at its next result and resumes when the slot frees.
// After reset, and on every open request, a clearing pass sets every map
// entry to unmapped and every valid count to zero; no request is taken
// meanwhile. The open request's erase result follows the pass.
module page_mapped_flash_translation (
	input  logic clk,
	input  logic arst_n,
	pmft_chan_if.sink   cmd,
	pmft_chan_if.source op
);
	import pmft_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CLEAR  = 5'd1;
	localparam logic [4:0] S_OPENER = 5'd2;
	localparam logic [4:0] S_NONE   = 5'd3;
	localparam logic [4:0] S_RMAP   = 5'd4;
	localparam logic [4:0] S_RMAPD  = 5'd5;
	localparam logic [4:0] S_WMAP   = 5'd6;
	localparam logic [4:0] S_WMAPD  = 5'd7;
	localparam logic [4:0] S_WOLD   = 5'd8;
	localparam logic [4:0] S_WOLDD  = 5'd9;
	localparam logic [4:0] S_WACT   = 5'd10;
	localparam logic [4:0] S_WPROG  = 5'd11;
	localparam logic [4:0] S_GSCAN  = 5'd12;
	localparam logic [4:0] S_GERASE = 5'd13;
	localparam logic [4:0] S_GPO    = 5'd14;
	localparam logic [4:0] S_GPOD   = 5'd15;
	localparam logic [4:0] S_GFMD   = 5'd16;
	localparam logic [4:0] S_GFIN0  = 5'd17;
	localparam logic [4:0] S_GFIN1  = 5'd18;
	localparam logic [4:0] S_GEND   = 5'd19;

	localparam int SCAN_W = BLK_W + 1;

	logic [4:0]       state_q;
	logic [CLR_W-1:0] clr_q;
	logic             open_q;
	logic [1:0]       st_q;
	logic [SEC_W-1:0] sector_q;
	logic [BLK_W-1:0] active_q, spare_q, victim_q, old_q;
	logic [CNT_W-1:0] fill_q, best_q, copied_q;
	logic [SCAN_W-1:0] scan_q;
	logic [PG_W-1:0]  page_q;

	logic out_valid_q;
	op_t  out_q;

	// RAM ports
	logic              fm_we, fm_re;
	logic [SEC_W-1:0]  fm_waddr, fm_raddr;
	logic [MAP_W-1:0]  fm_wdata, fm_rdata;
	logic              po_we, po_re;
	logic [PHYS_W-1:0] po_waddr, po_raddr;
	logic [SEC_W-1:0]  po_wdata, po_rdata;
	logic              vc_we, vc_re;
	logic [BLK_W-1:0]  vc_waddr, vc_raddr;
	logic [CNT_W-1:0]  vc_wdata, vc_rdata;

	logic             out_free, emit;
	op_t              emit_op;
	logic             last_page;
	logic             copy_hit;
	logic [BLK_W-1:0] scan_idx;

	pmft_ram #(.WIDTH(MAP_W), .DEPTH(LOGICAL_SECTORS)) u_fmap (
		.clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.re(fm_re), .raddr(fm_raddr), .rdata(fm_rdata)
	);
	pmft_ram #(.WIDTH(SEC_W), .DEPTH(BLOCKS * PAGES_PER_BLOCK)) u_owner (
		.clk(clk), .we(po_we), .waddr(po_waddr), .wdata(po_wdata),
		.re(po_re), .raddr(po_raddr), .rdata(po_rdata)
	);
	pmft_ram #(.WIDTH(CNT_W), .DEPTH(BLOCKS)) u_vcnt (
		.clk(clk), .we(vc_we), .waddr(vc_waddr), .wdata(vc_wdata),
		.re(vc_re), .raddr(vc_raddr), .rdata(vc_rdata)
	);

	assign out_free  = !out_valid_q || op.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign op.valid  = out_valid_q;
	assign op.payload = out_q;
	assign last_page = (page_q == PG_W'(PAGES_PER_BLOCK - 1));
	assign copy_hit  = (fm_rdata == {1'b0, victim_q, page_q});
	assign scan_idx  = scan_q[BLK_W-1:0] - BLK_W'(1);

	// RAM access and result selection per state
	always_comb begin
		fm_we = 1'b0; fm_waddr = sector_q; fm_wdata = NO_MAP;
		fm_re = 1'b0; fm_raddr = sector_q;
		po_we = 1'b0; po_waddr = {active_q, fill_q[PG_W-1:0]}; po_wdata = sector_q;
		po_re = 1'b0; po_raddr = {victim_q, page_q};
		vc_we = 1'b0; vc_waddr = old_q; vc_wdata = '0;
		vc_re = 1'b0; vc_raddr = active_q;
		emit = 1'b0;
		emit_op = '0;
		emit_op.flash_op = OP_NONE;
		case (state_q)
			S_CLEAR: begin
				fm_we = 1'b1;
				fm_waddr = clr_q[SEC_W-1:0];
				vc_we = (clr_q < CLR_W'(BLOCKS));
				vc_waddr = clr_q[BLK_W-1:0];
			end
			S_OPENER: begin
				emit = 1'b1;
				emit_op.flash_op = OP_ERASE;
				emit_op.last = 1'b1;
			end
			S_NONE: begin
				emit = 1'b1;
				emit_op.status = st_q;
				emit_op.last = 1'b1;
			end
			S_RMAP, S_WMAP: begin
				fm_re = 1'b1;
			end
			S_RMAPD: begin
				emit = 1'b1;
				emit_op.last = 1'b1;
				if (fm_rdata[MAP_W-1]) begin
					emit_op.status = ST_UNMAPPED;
				end else begin
					emit_op.flash_op = OP_READ;
					emit_op.target_block = fm_rdata[PHYS_W-1:PG_W];
					emit_op.target_page = fm_rdata[PG_W-1:0];
				end
			end
			S_WOLD: begin
				vc_re = 1'b1;
				vc_raddr = old_q;
			end
			S_WOLDD: begin
				vc_we = (vc_rdata != '0);
				vc_waddr = old_q;
				vc_wdata = vc_rdata - CNT_W'(1);
			end
			S_WACT: begin
				vc_re = 1'b1;
			end
			S_WPROG: begin
				emit = 1'b1;
				emit_op.flash_op = OP_PROG;
				emit_op.target_block = active_q;
				emit_op.target_page = fill_q[PG_W-1:0];
				emit_op.sector_tag = sector_q;
				emit_op.last = 1'b1;
				fm_we = out_free;
				fm_wdata = {1'b0, active_q, fill_q[PG_W-1:0]};
				po_we = out_free;
				vc_we = out_free;
				vc_waddr = active_q;
				vc_wdata = (vc_rdata < CNT_W'(PAGES_PER_BLOCK)) ?
					vc_rdata + CNT_W'(1) : vc_rdata;
			end
			S_GSCAN: begin
				vc_re = !scan_q[SCAN_W-1];
				vc_raddr = scan_q[BLK_W-1:0];
			end
			S_GERASE: begin
				emit = 1'b1;
				emit_op.flash_op = OP_ERASE;
				emit_op.target_block = spare_q;
			end
			S_GPO: begin
				po_re = 1'b1;
			end
			S_GPOD: begin
				fm_re = (po_rdata < SEC_W'(LOGICAL_SECTORS));
				fm_raddr = po_rdata;
			end
			S_GFMD: begin
				emit = copy_hit;
				emit_op.flash_op = OP_COPY;
				emit_op.target_block = spare_q;
				emit_op.target_page = copied_q[PG_W-1:0];
				emit_op.source_block = victim_q;
				emit_op.source_page = page_q;
				emit_op.sector_tag = po_rdata;
				fm_we = copy_hit && out_free;
				fm_waddr = po_rdata;
				fm_wdata = {1'b0, spare_q, copied_q[PG_W-1:0]};
				po_we = copy_hit && out_free;
				po_waddr = {spare_q, copied_q[PG_W-1:0]};
				po_wdata = po_rdata;
			end
			S_GFIN0: begin
				vc_we = 1'b1;
				vc_waddr = victim_q;
			end
			S_GFIN1: begin
				vc_we = 1'b1;
				vc_waddr = spare_q;
				vc_wdata = copied_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (op.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_q <= emit_op;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			open_q   <= 1'b0;
			st_q     <= ST_OK;
			sector_q <= '0;
			active_q <= '0;
			spare_q  <= BLK_W'(1);
			fill_q   <= '0;
			victim_q <= '0;
			old_q    <= '0;
			best_q   <= '0;
			copied_q <= '0;
			scan_q   <= '0;
			page_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						sector_q <= cmd.payload.sector;
						st_q <= ST_OK;
						case (cmd.payload.command)
							CMD_READ: begin
								if (cmd.payload.sector < SEC_W'(LOGICAL_SECTORS)) begin
									state_q <= S_RMAP;
								end else begin
									st_q <= ST_UNMAPPED;
									state_q <= S_NONE;
								end
							end
							CMD_WRITE: begin
								if (cmd.payload.sector >= SEC_W'(LOGICAL_SECTORS)) begin
									state_q <= S_NONE;
								end else if (fill_q >= CNT_W'(PAGES_PER_BLOCK)) begin
									scan_q <= '0;
									best_q <= CNT_W'(PAGES_PER_BLOCK + 1);
									victim_q <= '0;
									copied_q <= '0;
									page_q <= '0;
									state_q <= S_GSCAN;
								end else begin
									state_q <= S_WMAP;
								end
							end
							CMD_OPEN: begin
								active_q <= '0;
								spare_q <= BLK_W'(1);
								fill_q <= '0;
								clr_q <= '0;
								open_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							default: state_q <= S_NONE;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(LOGICAL_SECTORS - 1)) begin
						state_q <= open_q ? S_OPENER : S_IDLE;
					end
				end
				S_OPENER, S_NONE, S_RMAPD, S_WPROG: begin
					if (out_free) begin
						open_q <= 1'b0;
						if (state_q == S_WPROG) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_RMAP: state_q <= S_RMAPD;
				S_WMAP: state_q <= S_WMAPD;
				S_WMAPD: begin
					old_q <= fm_rdata[PHYS_W-1:PG_W];
					state_q <= fm_rdata[MAP_W-1] ? S_WACT : S_WOLD;
				end
				S_WOLD: state_q <= S_WOLDD;
				S_WOLDD: state_q <= S_WACT;
				S_WACT: state_q <= S_WPROG;
				// victim search, one count per cycle
				S_GSCAN: begin
					if (scan_q != '0) begin
						if (scan_idx != active_q && scan_idx != spare_q && vc_rdata < best_q) begin
							victim_q <= scan_idx;
							best_q <= vc_rdata;
						end
					end
					scan_q <= scan_q + SCAN_W'(1);
					if (scan_q == SCAN_W'(BLOCKS)) begin
						state_q <= S_GERASE;
					end
				end
				S_GERASE: begin
					if (out_free) begin
						state_q <= (best_q != '0) ? S_GPO : S_GEND;
					end
				end
				S_GPO: state_q <= S_GPOD;
				S_GPOD: begin
					if (po_rdata < SEC_W'(LOGICAL_SECTORS)) begin
						state_q <= S_GFMD;
					end else if (last_page) begin
						state_q <= S_GFIN0;
					end else begin
						page_q <= page_q + PG_W'(1);
						state_q <= S_GPO;
					end
				end
				S_GFMD: begin
					if (!copy_hit || out_free) begin
						if (copy_hit) begin
							copied_q <= copied_q + CNT_W'(1);
						end
						if (last_page) begin
							state_q <= S_GFIN0;
						end else begin
							page_q <= page_q + PG_W'(1);
							state_q <= S_GPO;
						end
					end
				end
				S_GFIN0: state_q <= S_GFIN1;
				S_GFIN1: state_q <= S_GEND;
				// role swap, then refuse or continue with the write
				S_GEND: begin
					active_q <= spare_q;
					spare_q <= victim_q;
					fill_q <= copied_q;
					if (copied_q >= CNT_W'(PAGES_PER_BLOCK)) begin
						st_q <= ST_FULL;
						state_q <= S_NONE;
					end else begin
						state_q <= S_WMAP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- dv/pmft_tb_pkg.sv -----
// Testbench constants for the page-mapped flash translation checks.
package pmft_tb_pkg;
	localparam int TB_LIMIT_CYCLES = 3000000;
endpackage

// ----- dv/tb_top.sv -----
// Self-checking testbench for the page-mapped flash translation controller.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pmft_pkg::*;

	localparam logic [1:0] CMD_RSVD = 2'd3;

	logic clk;
	logic arst_n;

	pmft_chan_if #(.T(cmd_t)) cmd_ch ();
	pmft_chan_if #(.T(op_t))  op_ch ();

	page_mapped_flash_translation DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .op(op_ch.source)
	);

	// predictor state
	logic [MAP_W-1:0] fwd_map [LOGICAL_SECTORS];
	logic [SEC_W-1:0] owner_tag [BLOCKS*PAGES_PER_BLOCK];
	int unsigned      valid_cnt [BLOCKS];
	int unsigned      act_blk, spare_blk, fill_ofs;

	cmd_t pending_reqs [$];
	op_t  expected_ops [$];
	int   errors;
	int   phase;          // 0,1,2 idling profile
	bit   hold_rx;        // long receiver stall
	bit   pause_tx;       // sender pause
	bit   cmd_acc;        // request taken at the last rising edge
	int   hold_cnt;
	longint cycles;

	task automatic report(input string what, input op_t got, input op_t exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	function automatic void clear_tables();
		for (int i = 0; i < LOGICAL_SECTORS; i++) fwd_map[i] = NO_MAP;
		for (int b = 0; b < BLOCKS; b++) valid_cnt[b] = 0;
		act_blk = 0; spare_blk = 1; fill_ofs = 0;
	endfunction

	function automatic void push_op(input logic [2:0] o, input int tb, input int tp,
			input int sb, input int sp, input int tag, input logic [1:0] st);
		op_t r;
		r.flash_op = o; r.target_block = 6'(tb); r.target_page = 5'(tp);
		r.source_block = 6'(sb); r.source_page = 5'(sp); r.sector_tag = SEC_W'(tag);
		r.status = st; r.last = 1'b0;
		expected_ops.push_back(r);
	endfunction

	// greedy collection into the spare block
	function automatic void collect_garbage();
		int unsigned victim, best, copied, phys, own, dst;
		victim = 0; best = PAGES_PER_BLOCK + 1; copied = 0;
		for (int b = 0; b < BLOCKS; b++)
			if (b != act_blk && b != spare_blk && valid_cnt[b] < best) begin
				victim = b; best = valid_cnt[b];
			end
		push_op(OP_ERASE, spare_blk, 0, 0, 0, 0, ST_OK);
		if (valid_cnt[victim] > 0) begin
			for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
				phys = victim*PAGES_PER_BLOCK + p;
				own = 32'(owner_tag[phys]);
				if (own < LOGICAL_SECTORS && 32'(fwd_map[own]) == phys) begin
					dst = spare_blk*PAGES_PER_BLOCK + copied;
					push_op(OP_COPY, spare_blk, copied, victim, p, own, ST_OK);
					owner_tag[dst] = SEC_W'(own);
					fwd_map[own] = MAP_W'(dst);
					copied++;
				end
			end
			valid_cnt[victim] = 0;
			valid_cnt[spare_blk] = copied;
		end
		act_blk = spare_blk; fill_ofs = copied; spare_blk = victim;
	endfunction

	function automatic void predict_request(input cmd_t c);
		int unsigned m, old, phys;
		int n0;
		n0 = expected_ops.size();
		if (c.command == CMD_READ) begin
			m = (c.sector < LOGICAL_SECTORS) ? 32'(fwd_map[c.sector]) : 32'(NO_MAP);
			if (m == 32'(NO_MAP) || m >= BLOCKS*PAGES_PER_BLOCK)
				push_op(OP_NONE, 0, 0, 0, 0, 0, ST_UNMAPPED);
			else
				push_op(OP_READ, m / PAGES_PER_BLOCK, m % PAGES_PER_BLOCK, 0, 0, 0, ST_OK);
		end else if (c.command == CMD_WRITE) begin
			if (c.sector >= LOGICAL_SECTORS) push_op(OP_NONE, 0, 0, 0, 0, 0, ST_OK);
			else begin
				if (fill_ofs >= PAGES_PER_BLOCK) collect_garbage();
				if (fill_ofs >= PAGES_PER_BLOCK) push_op(OP_NONE, 0, 0, 0, 0, 0, ST_FULL);
				else begin
					if (fwd_map[c.sector] != NO_MAP) begin
						old = 32'(fwd_map[c.sector]) / PAGES_PER_BLOCK;
						if (old < BLOCKS && valid_cnt[old] > 0) valid_cnt[old]--;
					end
					phys = act_blk*PAGES_PER_BLOCK + fill_ofs;
					push_op(OP_PROG, act_blk, fill_ofs, 0, 0, 32'(c.sector), ST_OK);
					owner_tag[phys] = c.sector;
					fwd_map[c.sector] = MAP_W'(phys);
					fill_ofs++;
					if (valid_cnt[act_blk] < PAGES_PER_BLOCK) valid_cnt[act_blk]++;
				end
			end
		end else if (c.command == CMD_OPEN) begin
			clear_tables();
			push_op(OP_ERASE, 0, 0, 0, 0, 0, ST_OK);
		end else push_op(OP_NONE, 0, 0, 0, 0, 0, ST_OK);
		expected_ops[expected_ops.size()-1].last = 1'b1;
		if (expected_ops.size() == n0) errors++;
	endfunction

	function automatic cmd_t mk(input logic [1:0] c, input int s);
		cmd_t r;
		r.command = c; r.sector = SEC_W'(s);
		return r;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// driver: offers requests at the falling edge
	initial begin
		cmd_ch.valid = 0;
		cmd_ch.payload = '0;
	end
	always @(negedge clk) begin
		bit idle;
		int pct;
		if (arst_n && (!cmd_ch.valid || cmd_acc)) begin
			pct = (phase == 0) ? 36 : (phase == 1) ? 83 : 0;
			idle = ($urandom_range(99) < pct) || pause_tx;
			if (!idle && pending_reqs.size() > 0) begin
				cmd_ch.payload <= pending_reqs.pop_front();
				cmd_ch.valid <= 1'b1;
			end else cmd_ch.valid <= 1'b0;
		end
	end

	// receiver ready at the falling edge
	initial op_ch.ready = 0;
	always @(negedge clk) begin
		int pct;
		pct = (phase == 0) ? 83 : (phase == 1) ? 36 : 0;
		if (hold_rx) begin
			op_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else op_ch.ready <= arst_n && ($urandom_range(99) >= pct);
	end

	// monitor: accepted requests feed the predictor, results are checked
	always @(posedge clk) begin
		op_t exp;
		cycles <= cycles + 1;
		cmd_acc = arst_n && cmd_ch.valid && cmd_ch.ready;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) predict_request(cmd_ch.payload);
			if (op_ch.valid && op_ch.ready) begin
				if (expected_ops.size() == 0) begin
					report("unexpected result", op_ch.payload, '0);
				end else begin
					exp = expected_ops.pop_front();
					if (op_ch.payload.flash_op !== exp.flash_op)
						report("flash_op", op_ch.payload, exp);
					if (op_ch.payload.target_block !== exp.target_block)
						report("target_block", op_ch.payload, exp);
					if (op_ch.payload.target_page !== exp.target_page)
						report("target_page", op_ch.payload, exp);
					if (op_ch.payload.source_block !== exp.source_block)
						report("source_block", op_ch.payload, exp);
					if (op_ch.payload.source_page !== exp.source_page)
						report("source_page", op_ch.payload, exp);
					if (op_ch.payload.sector_tag !== exp.sector_tag)
						report("sector_tag", op_ch.payload, exp);
					if (op_ch.payload.status !== exp.status)
						report("status", op_ch.payload, exp);
					if (op_ch.payload.last !== exp.last)
						report("last", op_ch.payload, exp);
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > pmft_tb_pkg::TB_LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || cmd_ch.valid || expected_ops.size() > 0)
			@(posedge clk);
	endtask

	// random request with mostly writes over a small hot range
	function automatic cmd_t rand_req();
		int k, s;
		k = $urandom_range(99);
		s = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(95);
		if (k < 60) return mk(CMD_WRITE, s);
		if (k < 95) return mk(CMD_READ, s);
		if (k < 98) return mk(CMD_RSVD, s);
		return mk(CMD_OPEN, s);
	endfunction

	// stimulus
	initial begin
		errors = 0; phase = 0; hold_rx = 0; pause_tx = 0; hold_cnt = 0; cycles = 0;
		for (int i = 0; i < BLOCKS*PAGES_PER_BLOCK; i++) owner_tag[i] = '0;
		clear_tables();
		// directed: unmapped read, extremes, unused command, open
		pending_reqs.push_back(mk(CMD_READ, 0));
		pending_reqs.push_back(mk(CMD_READ, 2047));
		pending_reqs.push_back(mk(CMD_WRITE, 0));
		pending_reqs.push_back(mk(CMD_WRITE, LOGICAL_SECTORS-1));
		pending_reqs.push_back(mk(CMD_WRITE, 2047));
		pending_reqs.push_back(mk(CMD_READ, 0));
		pending_reqs.push_back(mk(CMD_READ, LOGICAL_SECTORS-1));
		pending_reqs.push_back(mk(CMD_READ, LOGICAL_SECTORS));
		pending_reqs.push_back(mk(CMD_RSVD, 1365));
		pending_reqs.push_back(mk(CMD_WRITE, 0));
		pending_reqs.push_back(mk(CMD_OPEN, 682));
		pending_reqs.push_back(mk(CMD_READ, 0));
		wait_drained();
		// fill beyond a block on one sector so collection hits an empty victim
		for (int i = 0; i < 40; i++) pending_reqs.push_back(mk(CMD_WRITE, 5));
		// receiver holds off while sender keeps offering
		hold_rx = 1;
		while (hold_cnt < 400) @(posedge clk);
		hold_rx = 0;
		// sender pauses until every expected result is back
		pause_tx = 1;
		while (cmd_ch.valid || expected_ops.size() > 0) @(posedge clk);
		pause_tx = 0;
		wait_drained();
		for (phase = 0; phase < 3; phase++) begin
			for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
			wait_drained();
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_ops.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
